/* rtl/wcsm_pkg.sv */
// shared types, constants and helpers for the wildcard substring match core
// no dependencies; imported by every module of the core
package wcsm_pkg;

    localparam int DEFAULT_MAX_PAT = 16;
    localparam int TEXT_W          = 8;
    localparam int PAT_LEN_W       = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int PAT_REG_BYTES   = 16;
    // wide enough for any pattern length, byte count or MAX_PAT value
    localparam int CMP_W           = 7;

    typedef enum logic [1:0] {
        MODE_EXACT    = 2'd0,
        MODE_SUFFIX   = 2'd1,
        MODE_PREFIX   = 2'd2,
        MODE_CONTAINS = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_WILDCARD_MODE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [PAT_LEN_W-1:0]  pattern_len;
        mode_t                 mode;
    } cfg_t;

    // pattern byte k; bytes past the two registers read as zero
    function automatic logic [TEXT_W-1:0] pat_byte(input cfg_t cfg, input logic [CMP_W-1:0] k);
        logic [2*CFG_DATA_W-1:0] all_bytes;
        logic [2*CFG_DATA_W-1:0] shifted;
        all_bytes = {cfg.pattern_high, cfg.pattern_low};
        shifted   = all_bytes >> ({3'b000, k[3:0]} * 7'd8);
        if (k < CMP_W'(PAT_REG_BYTES))
            return shifted[TEXT_W-1:0];
        return '0;
    endfunction

endpackage

/* rtl/wildcard_anchored_substring_match_core.sv */
// top level of the wildcard substring match core: input register, matcher, result register
// depends on wcsm_pkg, wcsm_cfg and wcsm_match
//
// The core takes one text byte per cycle and, on the byte flagged text_last, returns one
// transfer whose matched bit says whether the text meets the configured pattern under the
// selected mode (exact, suffix, prefix or contains). Bytes not flagged last return nothing.
// A byte transfer lands in the input register; then the window/pattern compare runs on it
// and, for a last byte, the verdict goes into the result register, which drives out_valid
// and matched. Sustained rate is one byte per cycle, set by the single compare stage; the
// input keeps flowing while a result waits, and only a second last byte stalls behind an
// untaken result. Pattern registers are written through the cfg port (always ready); the
// user must write them only while no text is in flight, which the core does not enforce.
module wildcard_anchored_substring_match_core #(
    parameter int MAX_PAT = wcsm_pkg::DEFAULT_MAX_PAT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // text byte channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wcsm_pkg::TEXT_W-1:0]      text_byte,
    input  logic                             text_last,
    // verdict channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             matched,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wcsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wcsm_pkg::*;

    cfg_t              cfg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [TEXT_W-1:0] byte_reg;
    logic              last_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              matched_reg;

    logic              out_free;
    logic              advance;
    logic              match_now;

    assign cfg_ready = 1'b1;

    wcsm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    wcsm_match #(
        .MAX_PAT (MAX_PAT)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (byte_reg),
        .text_last (last_reg),
        .cfg       (cfg),
        .matched   (match_now)
    );

    // a non-last byte never needs the result register, so it always moves on
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            last_reg <= text_last;
        end
        if (advance && last_reg)
            matched_reg <= match_now;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

/* rtl/wcsm_cfg.sv */
// configuration register file of the wildcard substring match core
// depends on wcsm_pkg
module wcsm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [wcsm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [wcsm_pkg::CFG_DATA_W-1:0]  wr_data,
    output wcsm_pkg::cfg_t                   cfg
);
    import wcsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_PATTERN_LOW:   cfg_next.pattern_low  = wr_data;
                REG_PATTERN_HIGH:  cfg_next.pattern_high = wr_data;
                REG_PATTERN_LEN:   cfg_next.pattern_len  = wr_data[PAT_LEN_W-1:0];
                REG_WILDCARD_MODE: cfg_next.mode         = mode_t'(wr_data[1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{default: '0, mode: MODE_EXACT};
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/wcsm_match.sv */
// sliding window, byte count and hit flags, with the window/pattern compare
// depends on wcsm_pkg
module wcsm_match #(
    parameter int MAX_PAT = wcsm_pkg::DEFAULT_MAX_PAT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [wcsm_pkg::TEXT_W-1:0]   text_byte,
    input  logic                          text_last,
    input  wcsm_pkg::cfg_t                cfg,
    output logic                          matched
);
    import wcsm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAT + 2);
    localparam int WIN_AW = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;

    logic [TEXT_W-1:0] win_reg  [MAX_PAT];
    logic [TEXT_W-1:0] win_next [MAX_PAT];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              prefix_reg;
    logic              prefix_next;
    logic              found_reg;
    logic              found_next;

    logic [CNT_W-1:0]  cnt_inc;
    logic [CMP_W-1:0]  len_w;
    logic [CMP_W-1:0]  cnt_w;
    logic              len_ok;
    logic [MAX_PAT-1:0] hit;
    logic              tail;
    logic              prefix_now;
    logic              found_now;

    // window after the new byte shifts in, entry 0 newest
    always_comb
    begin
        win_next[0] = text_byte;
        for (int i = 1; i < MAX_PAT; i++)
            win_next[i] = win_reg[i-1];
    end

    assign cnt_inc = (cnt_reg <= CNT_W'(MAX_PAT)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign len_w   = CMP_W'(cfg.pattern_len);
    assign cnt_w   = CMP_W'(cnt_inc);
    assign len_ok  = len_w <= CMP_W'(MAX_PAT);

    // pattern byte k lines up with window entry len-1-k
    always_comb
    begin
        logic [CMP_W-1:0] d;
        for (int k = 0; k < MAX_PAT; k++)
        begin
            d = len_w - CMP_W'(1) - CMP_W'(k);
            if (CMP_W'(k) >= len_w)
                hit[k] = 1'b1;
            else
                hit[k] = (win_next[d[WIN_AW-1:0]] == pat_byte(cfg, CMP_W'(k)));
        end
    end

    assign tail       = len_ok && (cnt_w >= len_w) && (&hit);
    assign prefix_now = prefix_reg || (tail && (cnt_w == len_w));
    assign found_now  = found_reg || tail;

    always_comb
    begin
        if (!len_ok)
            matched = 1'b0;
        else
        begin
            case (cfg.mode)
                MODE_EXACT:    matched = tail && (cnt_w == len_w);
                MODE_SUFFIX:   matched = tail;
                MODE_PREFIX:   matched = (len_w == '0) || prefix_now;
                MODE_CONTAINS: matched = (len_w == '0) || found_now;
                default:       matched = 1'b0;
            endcase
        end
    end

    // per-text state clears after the last byte
    always_comb
    begin
        cnt_next    = cnt_reg;
        prefix_next = prefix_reg;
        found_next  = found_reg;
        if (step)
        begin
            if (text_last)
            begin
                cnt_next    = '0;
                prefix_next = 1'b0;
                found_next  = 1'b0;
            end
            else
            begin
                cnt_next    = cnt_inc;
                prefix_next = prefix_now;
                found_next  = found_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            prefix_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            prefix_reg <= prefix_next;
            found_reg  <= found_next;
        end
    end

    // window entries beyond the byte count are never compared
    always_ff @(posedge clk)
    begin
        if (step)
            win_reg <= win_next;
    end

endmodule

/* dv/tb_wildcard_anchored_substring_match_core.sv */
// self-checking testbench for wildcard_anchored_substring_match_core
// depends on wcsm_pkg and the core rtl; drives bytes and register writes, checks every verdict
module tb_wildcard_anchored_substring_match_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wcsm_pkg::*;

    localparam int MAX_PAT      = DEFAULT_MAX_PAT;
    // settle time before touching registers or ending, once every verdict is back
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1150;
    localparam int MAX_GAP      = 16;

    // what the sender does next: a text byte, a register write, or wait for the core to drain
    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_WRITE,
        ACT_DRAIN
    } action_kind_t;

    typedef struct {
        action_kind_t          kind;
        logic [TEXT_W-1:0]     data;
        logic                  last;
        reg_idx_t              idx;
        logic [CFG_DATA_W-1:0] value;
    } action_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [TEXT_W-1:0]     text_byte = '0;
    logic                  text_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  matched;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // planned byte and register traffic, filled once at time zero
    action_t     stream_plan[$];
    logic [7:0]  text_buf[$];
    // verdicts predicted for accepted last bytes, oldest first
    logic        expected_verdicts[$];

    // generator's view of the pattern it last programmed
    logic [127:0] plan_pat  = '0;
    int           plan_len  = 0;
    int           bytes_planned   = 0;
    int           settings_planned = 0;

    // predictor state: sliding window, saturating byte count, prefix and anywhere flags
    logic [7:0]            win_bytes[MAX_PAT] = '{default: 8'h00};
    int                    seen_count = 0;
    bit                    head_hit   = 1'b0;
    bit                    any_hit    = 1'b0;
    logic [CFG_DATA_W-1:0] cur_lo     = '0;
    logic [CFG_DATA_W-1:0] cur_hi     = '0;
    logic [PAT_LEN_W-1:0]  cur_len    = '0;
    mode_t                 cur_mode   = MODE_EXACT;

    // idling bookkeeping, each owned by one always block
    int  hold_cycles   = 0;
    int  settle_cycles = 0;
    int  stall_cycles  = 0;
    bit  send_quiet    = 1'b0;
    bit  recv_quiet    = 1'b1;

    int  bytes_accepted   = 0;
    int  verdicts_checked = 0;
    int  matches_seen     = 0;
    int  drains_done      = 0;
    int  mismatch_count   = 0;

    wildcard_anchored_substring_match_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .text_last (text_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // pattern byte k from the programmed registers; bytes past them read as zero
    function automatic logic [7:0] pattern_byte(input int k);
        if (k < 8)
            return cur_lo[k*8 +: 8];
        if (k < 16)
            return cur_hi[(k-8)*8 +: 8];
        return 8'h00;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PATTERN_LOW:   cur_lo   = value;
            REG_PATTERN_HIGH:  cur_hi   = value;
            REG_PATTERN_LEN:   cur_len  = value[PAT_LEN_W-1:0];
            REG_WILDCARD_MODE: cur_mode = mode_t'(value[1:0]);
            default:           ;
        endcase
    endfunction

    // shift one byte into the window and update the flags; returns 1 when the byte
    // ends a text, with the verdict in verdict
    function automatic bit advance_window(input logic [7:0] b, input logic last,
                                          output logic verdict);
        bit tail;
        int len;
        int k;
        for (k = MAX_PAT - 1; k > 0; k--)
            win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = b;
        if (seen_count <= MAX_PAT)
            seen_count++;

        // newest len bytes against the pattern, oldest window byte first
        len  = cur_len;
        tail = (len <= MAX_PAT) && (seen_count >= len);
        for (k = 0; k < len && tail; k++)
            if (win_bytes[len-1-k] != pattern_byte(k))
                tail = 1'b0;
        if (tail && seen_count == len)
            head_hit = 1'b1;
        if (tail)
            any_hit = 1'b1;

        verdict = 1'b0;
        if (!last)
            return 1'b0;

        // a pattern longer than the window never matches
        if (len <= MAX_PAT)
        begin
            case (cur_mode)
                MODE_EXACT:  verdict = tail && (seen_count == len);
                MODE_SUFFIX: verdict = tail;
                MODE_PREFIX: verdict = (len == 0) || head_hit;
                default:     verdict = (len == 0) || any_hit;
            endcase
        end
        seen_count = 0;
        head_hit   = 1'b0;
        any_hit    = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------

    task automatic plan_byte(input logic [7:0] b, input logic last);
        action_t act;
        act       = '{kind: ACT_BYTE, data: b, last: last, idx: REG_PATTERN_LOW, value: '0};
        stream_plan.insert(stream_plan.size(), act);
        bytes_planned++;
    endtask

    task automatic plan_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        action_t act;
        act = '{kind: ACT_WRITE, data: '0, last: 1'b0, idx: idx, value: value};
        stream_plan.insert(stream_plan.size(), act);
    endtask

    task automatic plan_drain();
        action_t act;
        act = '{kind: ACT_DRAIN, data: '0, last: 1'b0, idx: REG_PATTERN_LOW, value: '0};
        stream_plan.insert(stream_plan.size(), act);
    endtask

    // program a new pattern once the core has gone idle; upper bits of the narrow
    // registers carry junk that the core must drop
    task automatic plan_pattern(input int len, input mode_t mode, input logic [127:0] bytes);
        logic [CFG_DATA_W-1:0] junk;
        plan_drain();
        plan_write(REG_PATTERN_LOW, bytes[63:0]);
        plan_write(REG_PATTERN_HIGH, bytes[127:64]);
        junk = {$urandom, $urandom};
        plan_write(REG_PATTERN_LEN, {junk[CFG_DATA_W-1:PAT_LEN_W], len[PAT_LEN_W-1:0]});
        junk = {$urandom, $urandom};
        plan_write(REG_WILDCARD_MODE, {junk[CFG_DATA_W-1:2], mode});
        plan_pat = bytes;
        plan_len = len;
        settings_planned++;
    endtask

    // send the buffered text, flagging its final byte
    task automatic flush_text();
        int k;
        for (k = 0; k < text_buf.size(); k++)
            plan_byte(text_buf[k], k == text_buf.size() - 1);
    endtask

    // filler leans on pattern bytes so partial and overlapping hits show up
    function automatic logic [7:0] filler_byte();
        int body;
        body = (plan_len > MAX_PAT) ? MAX_PAT : plan_len;
        if (body > 0 && $urandom_range(0, 1) == 1)
            return plan_pat[$urandom_range(0, body - 1)*8 +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly the pattern wrapped in optional head and tail, some with one flipped bit,
    // the rest plain noise
    task automatic plan_random_text();
        int shape;
        int head;
        int tail;
        int body;
        int k;
        int pos;
        text_buf.delete();
        shape = $urandom_range(0, 99);
        body  = (plan_len > MAX_PAT) ? MAX_PAT : plan_len;
        if (shape < 80)
        begin
            // long heads push the byte count past its saturation point
            head = $urandom_range(0, 1) ? 0
                 : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 5);
            tail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
            for (k = 0; k < head; k++)
                text_buf.insert(text_buf.size(), filler_byte());
            for (k = 0; k < body; k++)
                text_buf.insert(text_buf.size(), plan_pat[k*8 +: 8]);
            for (k = 0; k < tail; k++)
                text_buf.insert(text_buf.size(), filler_byte());
            if (shape >= 60 && body > 0)
            begin
                pos = head + $urandom_range(0, body - 1);
                text_buf[pos] = text_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        else
        begin
            for (k = $urandom_range(1, 24); k > 0; k--)
                text_buf.insert(text_buf.size(), filler_byte());
        end
        // a text is never empty
        if (text_buf.size() == 0)
            text_buf.insert(text_buf.size(), filler_byte());
        flush_text();
    endtask

    // ------------------------------------------------------------------
    // sender: one transfer at a time on either the byte or the register channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sender
        logic    nxt_valid;
        logic    nxt_cfg;
        logic    verdict;
        action_t act;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = in_valid && !in_ready;
            nxt_cfg   = cfg_valid && !cfg_ready;

            // predict at the byte transfer itself, with the registers as they stand
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                if (advance_window(text_byte, text_last, verdict))
                    expected_verdicts.insert(expected_verdicts.size(), verdict);
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);

            if (!nxt_valid && !nxt_cfg && stream_plan.size() != 0)
            begin
                if (hold_cycles != 0)
                    hold_cycles--;
                else
                begin
                    act = stream_plan[0];
                    case (act.kind)
                        ACT_BYTE:
                        begin
                            stream_plan.delete(0);
                            nxt_valid = 1'b1;
                            text_byte <= act.data;
                            text_last <= act.last;
                            // alternate between gappy stretches and back-to-back bursts
                            if ($urandom_range(0, 31) == 0)
                                send_quiet = !send_quiet;
                            hold_cycles = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
                        end
                        ACT_WRITE:
                        begin
                            stream_plan.delete(0);
                            nxt_cfg = 1'b1;
                            cfg_index <= act.idx;
                            cfg_data  <= act.value;
                        end
                        default:
                        begin
                            // hold off until every verdict is back, then let the pipe settle
                            if (expected_verdicts.size() != 0)
                                settle_cycles = 0;
                            else if (settle_cycles >= DRAIN_CYCLES)
                            begin
                                stream_plan.delete(0);
                                settle_cycles = 0;
                                drains_done++;
                            end
                            else
                                settle_cycles++;
                        end
                    endcase
                end
            end
            in_valid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, every verdict checked against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s, expected matched=%b, got matched=%b",
                     $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : receiver
        logic want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                verdicts_checked++;
                if (matched === 1'b1)
                    matches_seen++;
                if (expected_verdicts.size() == 0)
                    report_mismatch("verdict with none outstanding", 1'bx, matched);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (matched !== want)
                        report_mismatch("wrong verdict", want, matched);
                end
                if ($urandom_range(0, 15) == 0)
                    recv_quiet = !recv_quiet;
                stall_cycles = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (stall_cycles != 0)
                stall_cycles--;
            out_ready <= (stall_cycles == 0);
        end
    end

    // ------------------------------------------------------------------
    // plan the whole run, then release reset
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          random_start;
        int          texts;
        int          k;
        int          r;
        int          len;
        bit          narrow_alphabet;
        logic [127:0] bytes;
        logic [7:0]  pick;

        // reset registers: empty pattern in exact mode can never match
        text_buf = '{8'h78};
        flush_text();

        // extreme byte values as the pattern, one text per mode
        plan_pattern(2, MODE_EXACT, 128'hFF00);
        text_buf = '{8'h00, 8'hFF};
        flush_text();
        plan_pattern(2, MODE_SUFFIX, 128'hFF00);
        text_buf = '{8'h41, 8'h00, 8'hFF};
        flush_text();
        plan_pattern(2, MODE_PREFIX, 128'hFF00);
        text_buf = '{8'h00, 8'hFF, 8'h41};
        flush_text();
        plan_pattern(2, MODE_CONTAINS, 128'hFF00);
        text_buf = '{8'h41, 8'h00, 8'hFF, 8'h41};
        flush_text();
        // empty pattern with both wildcards matches anything
        plan_pattern(0, MODE_CONTAINS, 128'h5F5F);
        text_buf = '{8'h71};
        flush_text();
        // a length past the window never matches
        plan_pattern(17, MODE_CONTAINS, 128'h0);
        text_buf = '{8'h00};
        flush_text();

        random_start = bytes_planned;
        while (bytes_planned - random_start < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 0;
            else if (r < 22)
                len = MAX_PAT;
            else if (r < 28)
                len = $urandom_range(MAX_PAT + 1, 31);
            else if (r < 80)
                len = $urandom_range(1, 5);
            else
                len = $urandom_range(1, MAX_PAT);

            // repetitive patterns exercise overlapping partial hits
            narrow_alphabet = $urandom_range(0, 1);
            for (k = 0; k < 16; k++)
            begin
                case ($urandom_range(0, 2))
                    0:       pick = 8'h61;
                    1:       pick = 8'h62;
                    default: pick = 8'h5F;
                endcase
                bytes[k*8 +: 8] = (narrow_alphabet && k < len) ? pick
                                : 8'($urandom_range(0, 255));
            end
            plan_pattern(len, mode_t'($urandom_range(0, 3)), bytes);

            for (texts = $urandom_range(4, 14);
                 texts > 0 && bytes_planned - random_start < RANDOM_BYTES; texts--)
            begin
                plan_random_text();
                // occasional full stop with no register change
                if ($urandom_range(0, 19) == 0)
                    plan_drain();
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // end of run: plan consumed, all verdicts back, pipe settled
    // ------------------------------------------------------------------
    initial
    begin : finish_run
        do
            @(negedge clk);
        while (!rst_n || stream_plan.size() != 0 || in_valid || cfg_valid
               || expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d text bytes under %0d pattern settings, %0d idle pauses",
                 bytes_accepted, settings_planned, drains_done);
        $display("compared %0d verdicts (%0d matches), %0d mismatches",
                 verdicts_checked, matches_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #(5_000_000);
        $display("run timed out with %0d verdicts outstanding", expected_verdicts.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/wcsm_pkg.sv
rtl/wcsm_cfg.sv
rtl/wcsm_match.sv
rtl/wildcard_anchored_substring_match_core.sv
dv/tb_wildcard_anchored_substring_match_core.sv
